### rtl/core/cbm_pkg.sv
// Shared types, constants and clamp functions of the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

	// Width of the ROM and RAM bank registers.
	localparam int ROM_BANK_BITS = 9;
	localparam int RAM_BANK_BITS = 4;

	// Widths of the bank count configuration registers.
	localparam int ROM_CNT_W = 10;
	localparam int RAM_CNT_W = 5;
	localparam int CFG_DATA_W = ROM_CNT_W;
	localparam int CFG_IDX_W = 2;
	localparam int PHYS_W = 23;

	localparam logic [ROM_CNT_W-1:0] ROM_MASK = ROM_CNT_W'((1 << ROM_BANK_BITS) - 1);
	localparam logic [RAM_CNT_W-1:0] RAM_MASK = RAM_CNT_W'((1 << RAM_BANK_BITS) - 1);
	localparam logic [7:0] RAM_MASK8 = 8'((1 << RAM_BANK_BITS) - 1);

	typedef enum logic [1:0] {
		CT_ROM_ONLY = 2'd0,
		CT_MBC1     = 2'd1,
		CT_MBC3     = 2'd2,
		CT_MBC5     = 2'd3
	} ctrl_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CTRL_TYPE = 2'd0,
		CFG_ROM_BANKS = 2'd1,
		CFG_RAM_BANKS = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		TGT_NONE      = 3'd0,
		TGT_ROM       = 3'd1,
		TGT_RAM       = 3'd2,
		TGT_RTC_REG   = 3'd3,
		TGT_RTC_LATCH = 3'd4
	} target_t;

	typedef struct packed {
		ctrl_t                ctrl;
		logic [ROM_CNT_W-1:0] rom_banks;
		logic [RAM_CNT_W-1:0] ram_count;
	} cfg_t;

	typedef struct packed {
		logic [ROM_BANK_BITS-1:0] rom_bank;
		logic [RAM_BANK_BITS-1:0] ram_sel;
		logic                     banking_mode;
		logic                     ram_en;
	} bank_state_t;

	typedef struct packed {
		target_t           tgt;
		logic [PHYS_W-1:0] phys;
		logic [2:0]        rtc_reg;
		logic              wr;
		logic [7:0]        data;
		logic              ram_en;
	} result_t;

	// Clamp a ROM bank number to the last bank present.
	function automatic logic [ROM_BANK_BITS-1:0] clamp_rom(input logic [15:0] v,
			input logic [ROM_CNT_W-1:0] banks);
		logic [ROM_CNT_W-1:0] lim;
		logic [ROM_CNT_W-1:0] vm;
		lim = (banks < ROM_CNT_W'(2)) ? ROM_CNT_W'(1) : banks - ROM_CNT_W'(1);
		if (lim > ROM_MASK)
			lim = ROM_MASK;
		vm = ROM_CNT_W'(v[ROM_BANK_BITS-1:0]);
		return (vm > lim) ? lim[ROM_BANK_BITS-1:0] : vm[ROM_BANK_BITS-1:0];
	endfunction

	// Clamp a RAM bank number to the last bank present; zero when there is no RAM.
	function automatic logic [RAM_BANK_BITS-1:0] clamp_ram(input logic [7:0] v,
			input logic [RAM_CNT_W-1:0] banks);
		logic [RAM_CNT_W-1:0] lim;
		logic [RAM_CNT_W-1:0] vm;
		lim = banks - RAM_CNT_W'(1);
		if (lim > RAM_MASK)
			lim = RAM_MASK;
		vm = RAM_CNT_W'(v[RAM_BANK_BITS-1:0]);
		if (banks == '0)
			return '0;
		return (vm > lim) ? lim[RAM_BANK_BITS-1:0] : vm[RAM_BANK_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/cbm_bank_regs.sv
// Configuration registers and mapper bank registers with their write decode.
`default_nettype none

module cbm_bank_regs import cbm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  upd,
	input  wire logic                  op,
	input  wire logic [15:0]           addr,
	input  wire logic [7:0]            data,
	output cfg_t                       cfg,
	output bank_state_t                cur,
	output bank_state_t                nxt
);

	cfg_t        cfg_q;
	bank_state_t state_q;

	logic [4:0]  lo5;
	logic [7:0]  v8;

	assign cfg = cfg_q;
	assign cur = state_q;

	// Bank register writes, decoded per controller type.
	always_comb begin
		nxt = state_q;
		lo5 = data[4:0];
		v8  = data & RAM_MASK8;
		if (lo5 == 5'd0)
			lo5 = 5'd1;
		if (op) begin
			case (cfg_q.ctrl)
				CT_MBC1: begin
					case (addr) inside
						[16'h0000:16'h1FFF]: nxt.ram_en = (data == 8'h0A);
						[16'h2000:16'h3FFF]: nxt.rom_bank = clamp_rom(
							(16'(state_q.rom_bank) & ~16'h001F) | 16'(lo5), cfg_q.rom_banks);
						[16'h4000:16'h5FFF]: begin
							if (!state_q.banking_mode)
								nxt.rom_bank = clamp_rom((16'(state_q.rom_bank) & 16'h001F)
									| {9'd0, data[1:0], 5'd0}, cfg_q.rom_banks);
							else
								nxt.ram_sel = clamp_ram({6'd0, data[1:0]}, cfg_q.ram_count);
						end
						[16'h6000:16'h7FFF]: begin
							if (data[0]) begin
								nxt.rom_bank = ROM_BANK_BITS'(16'(state_q.rom_bank) & 16'h001F);
								nxt.banking_mode = 1'b1;
							end else begin
								nxt.ram_sel = '0;
								nxt.banking_mode = 1'b0;
							end
						end
						default: ;
					endcase
				end
				CT_MBC3: begin
					case (addr) inside
						[16'h0000:16'h1FFF]: nxt.ram_en = (data[3:0] == 4'hA);
						[16'h2000:16'h3FFF]: begin
							if (data[6:0] == 7'd0)
								nxt.rom_bank = clamp_rom(16'd1, cfg_q.rom_banks);
							else
								nxt.rom_bank = clamp_rom({9'd0, data[6:0]}, cfg_q.rom_banks);
						end
						[16'h4000:16'h5FFF]: begin
							// Values 8 to 15 select a clock register and are kept as written.
							if (v8[3])
								nxt.ram_sel = v8[RAM_BANK_BITS-1:0];
							else
								nxt.ram_sel = clamp_ram(v8, cfg_q.ram_count);
						end
						default: ;
					endcase
				end
				CT_MBC5: begin
					case (addr) inside
						[16'h0000:16'h1FFF]: nxt.ram_en = (data[3:0] == 4'hA);
						[16'h2000:16'h2FFF]: nxt.rom_bank = clamp_rom(
							(16'(state_q.rom_bank) & 16'h0100) | {8'd0, data}, cfg_q.rom_banks);
						[16'h3000:16'h3FFF]: nxt.rom_bank = clamp_rom(
							(16'(state_q.rom_bank) & 16'h00FF) | {7'd0, data[0], 8'd0},
							cfg_q.rom_banks);
						[16'h4000:16'h5FFF]: nxt.ram_sel = clamp_ram({4'd0, data[3:0]},
							cfg_q.ram_count);
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctrl      <= CT_ROM_ONLY;
			cfg_q.rom_banks <= ROM_CNT_W'(2);
			cfg_q.ram_count <= '0;
			state_q.rom_bank     <= ROM_BANK_BITS'(1);
			state_q.ram_sel      <= '0;
			state_q.banking_mode <= 1'b0;
			state_q.ram_en       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_CTRL_TYPE: cfg_q.ctrl <= ctrl_t'(cfg_wdata[1:0]);
					CFG_ROM_BANKS: cfg_q.rom_banks <= cfg_wdata;
					CFG_RAM_BANKS: cfg_q.ram_count <= cfg_wdata[RAM_CNT_W-1:0];
					default: ;
				endcase
			end
			if (upd)
				state_q <= nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/core/cbm_translate.sv
// Address translation of one bus access into a ROM, RAM or clock target.
`default_nettype none

module cbm_translate import cbm_pkg::*; (
	input  wire logic        op,
	input  wire logic [15:0] addr,
	input  wire logic [7:0]  data,
	input  wire cfg_t        cfg,
	input  wire bank_state_t cur,
	input  wire bank_state_t nxt,
	output result_t          res
);

	logic       has_clock;
	logic [7:0] rb8;

	assign has_clock = (cfg.ctrl == CT_MBC3);
	assign rb8 = 8'(cur.ram_sel);

	always_comb begin
		res.tgt     = TGT_NONE;
		res.phys    = '0;
		res.rtc_reg = '0;
		res.wr      = 1'b0;

		if (op) begin
			if (has_clock && addr >= 16'h6000 && addr <= 16'h7FFF) begin
				res.tgt = TGT_RTC_LATCH;
				res.wr  = 1'b1;
			end
		end else if (addr <= 16'h3FFF) begin
			res.tgt  = TGT_ROM;
			res.phys = PHYS_W'(addr);
		end else if (addr <= 16'h7FFF) begin
			res.tgt  = TGT_ROM;
			res.phys = PHYS_W'({cur.rom_bank, addr[13:0]});
		end

		// The external RAM window; on the clock mapper a high bank selects a clock register.
		if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
			if (has_clock && rb8[3]) begin
				res.tgt     = TGT_RTC_REG;
				res.phys    = '0;
				res.rtc_reg = rb8[2:0];
				res.wr      = op;
			end else if (cfg.ram_count != '0) begin
				res.tgt  = TGT_RAM;
				res.phys = PHYS_W'({cur.ram_sel, addr[12:0]});
				res.wr   = op;
			end
		end

		res.data   = res.wr ? data : 8'd0;
		res.ram_en = nxt.ram_en;
	end

endmodule

`default_nettype wire

### rtl/core/cartridge_bank_mapper_core.sv
// Top level of the cartridge bank mapper: handshakes, pipeline registers and submodules.
`default_nettype none

// Channel   Handshake                 Word
// --------  ------------------------  -------------------------------------------------
// in        in_valid / in_ready       operation, bus_address, bus_data
// out       out_valid / out_ready     target, physical_address, rtc_register,
//                                     store_write, store_data, ram_enabled
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A new input word is taken in every cycle unless the output stalls and both registers are full.
// An accepted word lands in the input register and is translated there; when it moves on, it
// updates the bank registers and is loaded into the result register, from which it leaves
// once the output takes it.
// A stalled output holds its word; the input register keeps filling until it too is
// blocked, so in_ready drops only when both registers hold words.
// Reset clears the valid flags, restores the configuration defaults and sets ROM bank one.
// Configuration writes are always taken (cfg_ready is tied high).

module cartridge_bank_mapper_core import cbm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  operation,
	input  wire logic [15:0]           bus_address,
	input  wire logic [7:0]            bus_data,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 target,
	output logic [PHYS_W-1:0]          physical_address,
	output logic [2:0]                 rtc_register,
	output logic                       store_write,
	output logic [7:0]                 store_data,
	output logic                       ram_enabled,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Input register.
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// Result register.
	logic        valid_s2;
	result_t     res_s2;

	logic        adv;
	cfg_t        cfg;
	bank_state_t cur_state;
	bank_state_t nxt_state;
	result_t     res;

	// The word in the input register moves on when the result register is free or drains.
	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	cbm_bank_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.upd       (adv),
		.op        (op_s1),
		.addr      (addr_s1),
		.data      (data_s1),
		.cfg       (cfg),
		.cur       (cur_state),
		.nxt       (nxt_state)
	);

	cbm_translate u_xlate (
		.op   (op_s1),
		.addr (addr_s1),
		.data (data_s1),
		.cfg  (cfg),
		.cur  (cur_state),
		.nxt  (nxt_state),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			addr_s1 <= bus_address;
			data_s1 <= bus_data;
		end
		if (adv)
			res_s2 <= res;
	end

	assign out_valid        = valid_s2;
	assign target           = res_s2.tgt;
	assign physical_address = res_s2.phys;
	assign rtc_register     = res_s2.rtc_reg;
	assign store_write      = res_s2.wr;
	assign store_data       = res_s2.data;
	assign ram_enabled      = res_s2.ram_en;

endmodule

`default_nettype wire

### rtl/core/cbm_checker.sv
// Port-level checker of the cartridge bank mapper and its bind to the top level.
`default_nettype none

module cbm_port_checks import cbm_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [2:0]        target,
	input wire logic [PHYS_W-1:0] physical_address,
	input wire logic [2:0]        rtc_register,
	input wire logic              store_write,
	input wire logic [7:0]        store_data
);

	a_tgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> target <= TGT_RTC_LATCH)
		else $error("target code out of range");

	a_phys_only_store: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != TGT_ROM && target != TGT_RAM |-> physical_address == '0)
		else $error("physical address set for a target without a store");

	a_rtc_reg_only_rtc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != TGT_RTC_REG |-> rtc_register == 3'd0)
		else $error("clock register index set for another target");

	a_strobe_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_write |-> target != TGT_NONE && target != TGT_ROM)
		else $error("write strobe toward no target or ROM");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target) && $stable(store_data))
		else $error("stalled output word changed");

endmodule

bind cartridge_bank_mapper_core cbm_port_checks u_cbm_port_checks (.*);

`default_nettype wire

### tb/cbm_checker.sv
// Watches the bus and result channels of the bank mapper, predicts every translation and compares.
`timescale 1ns / 100ps

module cbm_checker import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  operation,
	input  logic [15:0]           bus_address,
	input  logic [7:0]            bus_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [2:0]            target,
	input  logic [PHYS_W-1:0]     physical_address,
	input  logic [2:0]            rtc_register,
	input  logic                  store_write,
	input  logic [7:0]            store_data,
	input  logic                  ram_enabled,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    checked
);

	localparam int ROM_SEL_MASK = (1 << ROM_BANK_BITS) - 1;
	localparam int RAM_SEL_MASK = (1 << RAM_BANK_BITS) - 1;

	// Mapper settings and bank registers as the checker sees them.
	ctrl_t                mapper_kind;
	logic [ROM_CNT_W-1:0] rom_count;
	logic [RAM_CNT_W-1:0] ram_count;
	int                   cur_rom;
	int                   cur_ram;
	logic                 mode_ram;
	logic                 en_flag;

	result_t translations_due[$];
	int      errs;
	int      seen;

	function automatic int fit_rom(input int v);
		int lim;
		lim = (rom_count < 2) ? 1 : int'(rom_count) - 1;
		if (lim > ROM_SEL_MASK)
			lim = ROM_SEL_MASK;
		v = v & ROM_SEL_MASK;
		return (v > lim) ? lim : v;
	endfunction

	function automatic int fit_ram(input int v);
		int lim;
		if (ram_count == 0)
			return 0;
		lim = int'(ram_count) - 1;
		if (lim > RAM_SEL_MASK)
			lim = RAM_SEL_MASK;
		v = v & RAM_SEL_MASK;
		return (v > lim) ? lim : v;
	endfunction

	// Updates the bank registers for one access and returns the word the block should give.
	task automatic translate_access(input logic wr, input logic [15:0] a, input logic [7:0] d,
			output result_t r);
		int addr;
		int data;
		int v;
		addr = int'(a);
		data = int'(d);
		r = '0;
		if (wr) begin
			case (mapper_kind)
				CT_MBC1: begin
					if (addr < 'h2000) begin
						en_flag = (d == 8'h0A);
					end else if (addr < 'h4000) begin
						v = data & 'h1F;
						if (v == 0)
							v = 1;
						cur_rom = fit_rom((cur_rom & ~'h1F) | v);
					end else if (addr < 'h6000) begin
						if (!mode_ram)
							cur_rom = fit_rom((cur_rom & 'h1F) | ((data & 3) << 5));
						else
							cur_ram = fit_ram(data & 3);
					end else if (addr < 'h8000) begin
						if (d[0]) begin
							cur_rom = cur_rom & 'h1F;
							mode_ram = 1'b1;
						end else begin
							cur_ram = 0;
							mode_ram = 1'b0;
						end
					end
				end
				CT_MBC3: begin
					if (addr < 'h2000) begin
						en_flag = (d[3:0] == 4'hA);
					end else if (addr < 'h4000) begin
						v = data & 'h7F;
						if (v == 0)
							v = 1;
						cur_rom = fit_rom(v);
					end else if (addr < 'h6000) begin
						v = data & RAM_SEL_MASK;
						cur_ram = ((v & 8) != 0) ? v : fit_ram(v);
					end
				end
				CT_MBC5: begin
					if (addr < 'h2000) begin
						en_flag = (d[3:0] == 4'hA);
					end else if (addr < 'h3000) begin
						cur_rom = fit_rom((cur_rom & 'h100) | data);
					end else if (addr < 'h4000) begin
						cur_rom = fit_rom((cur_rom & 'hFF) | ((data & 1) << 8));
					end else if (addr < 'h6000) begin
						cur_ram = fit_ram(data & 'hF);
					end
				end
				default: ;
			endcase
			if (mapper_kind == CT_MBC3 && addr >= 'h6000 && addr < 'h8000) begin
				r.tgt = TGT_RTC_LATCH;
				r.wr = 1'b1;
			end
		end else if (addr < 'h4000) begin
			r.tgt = TGT_ROM;
			r.phys = PHYS_W'(addr);
		end else if (addr < 'h8000) begin
			r.tgt = TGT_ROM;
			r.phys = PHYS_W'((cur_rom & ROM_SEL_MASK) * 'h4000 + addr - 'h4000);
		end
		if (addr >= 'hA000 && addr < 'hC000) begin
			if (mapper_kind == CT_MBC3 && (cur_ram & 8) != 0) begin
				r.tgt = TGT_RTC_REG;
				r.rtc_reg = 3'(cur_ram - 8);
				r.wr = wr;
			end else if (ram_count != 0) begin
				r.tgt = TGT_RAM;
				r.phys = PHYS_W'((cur_ram & RAM_SEL_MASK) * 'h2000 + addr - 'hA000);
				r.wr = wr;
			end
		end
		r.data = r.wr ? d : 8'h00;
		r.ram_en = en_flag;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t made;
		if (!arst_n) begin
			mapper_kind = CT_ROM_ONLY;
			rom_count = ROM_CNT_W'(2);
			ram_count = '0;
			cur_rom = 1;
			cur_ram = 0;
			mode_ram = 1'b0;
			en_flag = 1'b0;
			translations_due.delete();
			errs = 0;
			seen = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CTRL_TYPE: mapper_kind = ctrl_t'(cfg_data[1:0]);
					CFG_ROM_BANKS: rom_count = cfg_data[ROM_CNT_W-1:0];
					CFG_RAM_BANKS: ram_count = cfg_data[RAM_CNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen++;
				if (translations_due.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result word %0d arrived with nothing outstanding",
							$realtime, seen);
				end else begin
					want = translations_due.pop_front();
					if (target !== want.tgt || physical_address !== want.phys ||
							rtc_register !== want.rtc_reg || store_write !== want.wr ||
							store_data !== want.data || ram_enabled !== want.ram_en) begin
						errs++;
						if (errs <= 10) begin
							$display("%0t: word %0d mismatch (exp/got): target %0d/%0d phys %06h/%06h",
								$realtime, seen, want.tgt, target, want.phys, physical_address);
							$display("    rtc %0d/%0d wr %0b/%0b data %02h/%02h en %0b/%0b",
								want.rtc_reg, rtc_register, want.wr, store_write,
								want.data, store_data, want.ram_en, ram_enabled);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				translate_access(operation, bus_address, bus_data, made);
				translations_due.push_back(made);
			end
			fail_count <= errs;
			pending <= translations_due.size();
			checked <= seen;
		end
	end

endmodule

### tb/tb_cartridge_bank_mapper_core.sv
// Stimulus, output flow control and verdict for the cartridge bank mapper core.
`timescale 1ns / 100ps

module tb_cartridge_bank_mapper_core;
	import cbm_pkg::*;

	// The cap is far above the slowest legal run, with every word waiting out the longest
	// gaps and stalls.
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_WORDS = 1925;
	localparam int SQUEEZE_CYCLES = 400;
	// A word passes the input and result registers before it leaves; this margin covers that.
	localparam int DRAIN_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	logic [15:0]           bus_address;
	logic [7:0]            bus_data;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            target;
	logic [PHYS_W-1:0]     physical_address;
	logic [2:0]            rtc_register;
	logic                  store_write;
	logic [7:0]            store_data;
	logic                  ram_enabled;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   fail_count;
	int   pending;
	int   checked;
	int   cycles = 0;
	int   sent = 0;
	int   settings_used = 0;
	logic steady_sender = 1'b0;
	logic squeeze_req = 1'b0;
	logic squeeze_on = 1'b0;

	cartridge_bank_mapper_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.bus_address      (bus_address),
		.bus_data         (bus_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.target           (target),
		.physical_address (physical_address),
		.rtc_register     (rtc_register),
		.store_write      (store_write),
		.store_data       (store_data),
		.ram_enabled      (ram_enabled),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	cbm_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.bus_address      (bus_address),
		.bus_data         (bus_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.target           (target),
		.physical_address (physical_address),
		.rtc_register     (rtc_register),
		.store_write      (store_write),
		.store_data       (store_data),
		.ram_enabled      (ram_enabled),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending          (pending),
		.checked          (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake anywhere ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words outstanding.", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Output flow control. Stretches of ready alternate with stalls, most stalls short and
	// a few long; now and then a long ready stretch leaves the output free-running. When the
	// stimulus asks for it, the output is held off once for a long time so that both
	// internal registers fill and in_ready has to drop.
	initial begin : result_pacing
		int   span;
		logic level;
		logic squeezed;
		squeezed = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				squeeze_on = 1'b1;
				level = 1'b0;
				span = SQUEEZE_CYCLES;
			end else if ($urandom_range(0, 3) != 0) begin
				level = 1'b1;
				span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
			end else begin
				level = 1'b0;
				span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
			end
			out_ready <= level;
			repeat (span) @(negedge clk);
		end
	end

	// Idle cycles before the next bus word: usually none, sometimes a few, rarely many.
	function automatic int sender_gap();
		int r;
		if (steady_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one bus word. Entered at a falling edge, returns at the falling edge after the
	// word was taken, so the next word can follow with valid left high.
	task automatic send_access(input logic op, input logic [15:0] a, input logic [7:0] d);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		bus_address <= a;
		bus_data <= d;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	// Drops valid and waits until every translation has come back and the pipe is empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Settings are only changed with the block idle. The bank registers keep their values
	// across a change, so later words also see banks beyond the new limits.
	task automatic configure(input ctrl_t kind, input int roms, input int rams);
		settle();
		write_reg(CFG_CTRL_TYPE, int'(kind));
		write_reg(CFG_ROM_BANKS, roms);
		write_reg(CFG_RAM_BANKS, rams);
		settings_used++;
	endtask

	function automatic int pick_rom_count();
		case ($urandom_range(0, 5))
			0: return 2;
			1: return 512;
			2: return $urandom_range(2, 40);
			3: return 1 << $urandom_range(1, 9);
			default: return $urandom_range(2, 512);
		endcase
	endfunction

	function automatic int pick_ram_count();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16;
			2: return 1;
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Random bus word. Most words are bank register writes or reads across the ROM area,
	// so that the translation keeps moving across banks; the others go to the RAM window
	// or anywhere in the address map.
	task automatic make_access(output logic op, output logic [15:0] a, output logic [7:0] d);
		int r;
		r = $urandom_range(0, 99);
		d = 8'($urandom_range(0, 255));
		if (r < 32) begin
			op = 1'b1;
			a = 16'($urandom_range(0, 'h7FFF));
			case ($urandom_range(0, 4))
				0: d = 8'h0A;
				1: d = 8'(($urandom_range(0, 15) << 4) | 'hA);
				2: d = 8'($urandom_range(0, 15));
				default: ;
			endcase
		end else if (r < 66) begin
			op = 1'b0;
			a = 16'($urandom_range(0, 'h7FFF));
		end else if (r < 86) begin
			op = 1'($urandom_range(0, 1));
			a = 16'($urandom_range('hA000, 'hBFFF));
		end else begin
			op = 1'($urandom_range(0, 1));
			a = 16'($urandom_range(0, 'hFFFF));
		end
	endtask

	initial begin : stimulus
		logic       op;
		logic [15:0] a;
		logic [7:0]  d;
		int         burst;
		int         done_words;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 1'b0;
		bus_address = '0;
		bus_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CTRL_TYPE;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings, ROM only without RAM: fixed bank, writes change nothing, the RAM
		// window and the top of the map answer with no target.
		send_access(1'b0, 16'h0000, 8'h00);
		send_access(1'b0, 16'hFFFF, 8'hFF);
		send_access(1'b1, 16'h2000, 8'hFF);
		send_access(1'b0, 16'h7FFF, 8'h00);
		send_access(1'b0, 16'hA000, 8'h00);

		// MBC1 with the largest sizes: exact enable code, zero bank turning into one, upper
		// bank bits, then RAM mode clearing them and selecting a RAM bank.
		configure(CT_MBC1, 512, 16);
		send_access(1'b1, 16'h0000, 8'h0A);
		send_access(1'b1, 16'h2000, 8'h00);
		send_access(1'b1, 16'h4000, 8'h03);
		send_access(1'b0, 16'h4000, 8'h00);
		send_access(1'b1, 16'h6000, 8'h01);
		send_access(1'b1, 16'h4000, 8'h02);
		send_access(1'b1, 16'hBFFF, 8'hFF);
		send_access(1'b0, 16'h4001, 8'h00);

		// MBC3 with the smallest ROM: bank clamped to the last one, clock register select,
		// clock write and latch, nibble enable code.
		configure(CT_MBC3, 2, 16);
		send_access(1'b1, 16'h2000, 8'h7F);
		send_access(1'b1, 16'h4000, 8'h0C);
		send_access(1'b1, 16'hA123, 8'h55);
		send_access(1'b1, 16'h6000, 8'h01);
		send_access(1'b1, 16'h0000, 8'h1A);
		send_access(1'b1, 16'h4000, 8'h0F);

		// MBC5: bank bit eight from the upper register, bank zero allowed in the low byte,
		// RAM bank clamp, and a write outside the register range.
		configure(CT_MBC5, 512, 4);
		send_access(1'b1, 16'h3000, 8'h01);
		send_access(1'b1, 16'h2000, 8'h00);
		send_access(1'b0, 16'h7FFF, 8'h00);
		send_access(1'b1, 16'h4000, 8'h0F);
		send_access(1'b0, 16'hBFFF, 8'h00);
		send_access(1'b1, 16'h8000, 8'hAA);

		// Random part: bursts of words under changing settings. One burst in four runs
		// without sender gaps; the long output stall is requested partway through.
		done_words = 0;
		while (done_words < RANDOM_WORDS) begin
			configure(ctrl_t'($urandom_range(0, 3)), pick_rom_count(), pick_ram_count());
			steady_sender = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(40, 220);
			if (burst > RANDOM_WORDS - done_words)
				burst = RANDOM_WORDS - done_words;
			if (done_words >= 400 && !squeeze_req) begin
				// Start a gapless burst only once the output is held off, so the
				// block fills up and its input stalls.
				squeeze_req = 1'b1;
				steady_sender = 1'b1;
				wait (squeeze_on);
			end
			repeat (burst) begin
				make_access(op, a, d);
				send_access(op, a, d);
				done_words++;
			end
		end
		steady_sender = 1'b0;
		settle();

		$display("Checked %0d result words for %0d bus words under %0d mapper settings.",
			checked, sent, settings_used);
		$display("Settings spanned all controller kinds and bank counts from smallest to largest.");
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
rtl/core/cbm_pkg.sv
rtl/core/cbm_bank_regs.sv
rtl/core/cbm_translate.sv
rtl/core/cartridge_bank_mapper_core.sv
rtl/core/cbm_checker.sv
tb/cbm_checker.sv
tb/tb_cartridge_bank_mapper_core.sv
